// ===== rtl/core/ptt_pkg.sv =====
// Shared types, token codes and character classes for the proof text tokenizer.
package ptt_pkg;

    localparam logic [3:0] KIND_EOF    = 4'd0;
    localparam logic [3:0] KIND_CONST  = 4'd1;
    localparam logic [3:0] KIND_VAR    = 4'd2;
    localparam logic [3:0] KIND_STAR   = 4'd3;
    localparam logic [3:0] KIND_PLUS   = 4'd4;
    localparam logic [3:0] KIND_MINUS  = 4'd5;
    localparam logic [3:0] KIND_COMMA  = 4'd6;
    localparam logic [3:0] KIND_PCT    = 4'd7;
    localparam logic [3:0] KIND_SEMI   = 4'd8;
    localparam logic [3:0] KIND_EQ     = 4'd9;
    localparam logic [3:0] KIND_LPAREN = 4'd10;
    localparam logic [3:0] KIND_RPAREN = 4'd11;
    localparam logic [3:0] KIND_ERROR  = 4'd12;

    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam logic       CMD_BYTE  = 1'b0;
    localparam logic       CMD_END   = 1'b1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    typedef struct packed {
        logic [3:0]  kind;
        logic [31:0] start;
        logic [31:0] length;
        logic [31:0] line;
        logic [63:0] value;
        logic        fits;
        logic [7:0]  bad;
    } t_tok;

    typedef struct packed {
        logic has_run;
        t_tok run;
        logic has_own;
        t_tok own;
    } t_entry;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
    endfunction

    function automatic logic [3:0] punct_kind(input logic [7:0] b);
        logic [3:0] k;
        unique case (b)
            CH_STAR:   k = KIND_STAR;
            CH_PLUS:   k = KIND_PLUS;
            CH_MINUS:  k = KIND_MINUS;
            CH_COMMA:  k = KIND_COMMA;
            CH_PCT:    k = KIND_PCT;
            CH_SEMI:   k = KIND_SEMI;
            CH_EQ:     k = KIND_EQ;
            CH_LPAREN: k = KIND_LPAREN;
            CH_RPAREN: k = KIND_RPAREN;
            default:   k = KIND_EOF;
        endcase
        return k;
    endfunction

endpackage

// ===== rtl/core/ptt_if.sv =====
// Channel interfaces: text byte input and token output.
interface ptt_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] byte_value;

    modport source(output valid, cmd, byte_value, input ready);
    modport sink(input valid, cmd, byte_value, output ready);
endinterface

interface ptt_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_kind;
    logic [31:0] start_offset;
    logic [31:0] token_length;
    logic [31:0] line_number;
    logic [63:0] const_value;
    logic        const_fits;
    logic [7:0]  bad_char;
    logic        last_of_run;

    modport source(output valid, token_kind, start_offset, token_length, line_number,
                   const_value, const_fits, bad_char, last_of_run, input ready);
    modport sink(input valid, token_kind, start_offset, token_length, line_number,
                 const_value, const_fits, bad_char, last_of_run, output ready);
endinterface

// ===== rtl/core/ptt_front.sv =====
// Front end: accepts text bytes, tracks runs and counters, queues token records.
module ptt_front #(
    parameter int OFFSET_BITS = 32,
    parameter int VALUE_BITS  = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ptt_in_if.sink            i_in,
    input  logic              i_q_full,
    output logic              o_push,
    output ptt_pkg::t_entry   o_entry
);

    localparam logic [1:0] RUN_NONE  = 2'd0;
    localparam logic [1:0] RUN_CONST = 2'd1;
    localparam logic [1:0] RUN_VAR   = 2'd2;

    logic [1:0]             r_run_kind, n_run_kind;
    logic [OFFSET_BITS-1:0] r_run_start, n_run_start;
    logic [OFFSET_BITS-1:0] r_run_len, n_run_len;
    logic [OFFSET_BITS-1:0] r_offset, n_offset;
    logic [OFFSET_BITS-1:0] r_line, n_line;
    logic [VALUE_BITS-1:0]  r_acc, n_acc;
    logic                   r_fits, n_fits;
    logic                   r_err, n_err;

    logic                   accept;
    logic                   cmd;
    logic [7:0]             b;
    logic                   run_active;
    logic                   cont;
    logic                   b_digit;
    logic                   b_alpha;
    logic                   b_space;
    logic [3:0]             pk;
    logic [VALUE_BITS-1:0]  acc_base;
    logic [VALUE_BITS+3:0]  acc_ext;
    logic [VALUE_BITS+3:0]  acc_sum;
    logic                   fits_base;
    logic [VALUE_BITS-1:0]  acc_new;
    logic                   fits_new;

    function automatic logic [31:0] to32(input logic [OFFSET_BITS-1:0] x);
        logic [63:0] w;
        w = '0;
        w[OFFSET_BITS-1:0] = x;
        return w[31:0];
    endfunction

    function automatic logic [63:0] to64(input logic [VALUE_BITS-1:0] x);
        logic [63:0] w;
        w = '0;
        w[VALUE_BITS-1:0] = x;
        return w;
    endfunction

    function automatic logic [OFFSET_BITS-1:0] sat_inc(input logic [OFFSET_BITS-1:0] x);
        return (&x) ? x : x + 1'b1;
    endfunction

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && !i_q_full;
    assign cmd        = i_in.cmd;
    assign b          = i_in.byte_value;

    assign b_digit    = ptt_pkg::is_digit(b);
    assign b_alpha    = ptt_pkg::is_alpha(b);
    assign b_space    = ptt_pkg::is_space(b);
    assign pk         = ptt_pkg::punct_kind(b);
    assign run_active = (r_run_kind != RUN_NONE);
    assign cont       = run_active && (cmd == ptt_pkg::CMD_BYTE) &&
                        ((r_run_kind == RUN_CONST) ? b_digit : (b_digit || b_alpha));

    // value*10 + digit with four guard bits; any guard bit set means overflow
    assign acc_base  = cont ? r_acc : '0;
    assign fits_base = cont ? r_fits : 1'b1;
    assign acc_ext   = {4'b0000, acc_base};
    assign acc_sum   = (acc_ext << 3) + (acc_ext << 1) +
                       (VALUE_BITS+4)'(b - ptt_pkg::CH_ZERO);
    assign acc_new   = acc_sum[VALUE_BITS-1:0];
    assign fits_new  = fits_base && !(|acc_sum[VALUE_BITS+3:VALUE_BITS]);

    always_comb begin
        n_run_kind  = r_run_kind;
        n_run_start = r_run_start;
        n_run_len   = r_run_len;
        n_offset    = r_offset;
        n_line      = r_line;
        n_acc       = r_acc;
        n_fits      = r_fits;
        n_err       = r_err;
        o_entry     = '0;
        o_push      = 1'b0;

        o_entry.run.kind   = (r_run_kind == RUN_CONST) ? ptt_pkg::KIND_CONST
                                                       : ptt_pkg::KIND_VAR;
        o_entry.run.start  = to32(r_run_start);
        o_entry.run.length = to32(r_run_len);
        o_entry.run.line   = to32(r_line);
        o_entry.run.value  = (r_run_kind == RUN_CONST) ? to64(r_acc) : '0;
        o_entry.run.fits   = (r_run_kind == RUN_CONST) && r_fits;
        o_entry.own.start  = to32(r_offset);
        o_entry.own.line   = to32(r_line);

        if (accept) begin
            if (r_err) begin
                if (cmd == ptt_pkg::CMD_END) begin
                    n_run_kind  = RUN_NONE;
                    n_run_start = '0;
                    n_run_len   = '0;
                    n_offset    = '0;
                    n_line      = OFFSET_BITS'(1);
                    n_acc       = '0;
                    n_fits      = 1'b1;
                    n_err       = 1'b0;
                end
            end else if (cont) begin
                n_run_len = sat_inc(r_run_len);
                if (r_run_kind == RUN_CONST) begin
                    n_acc  = acc_new;
                    n_fits = fits_new;
                end
                n_offset = r_offset + 1'b1;
            end else begin
                o_entry.has_run = run_active;
                n_run_kind      = RUN_NONE;
                n_offset        = r_offset + 1'b1;
                if (cmd == ptt_pkg::CMD_END) begin
                    o_entry.has_own    = 1'b1;
                    o_entry.own.kind   = ptt_pkg::KIND_EOF;
                    o_entry.own.length = '0;
                    n_run_start        = '0;
                    n_run_len          = '0;
                    n_offset           = '0;
                    n_line             = OFFSET_BITS'(1);
                    n_acc              = '0;
                    n_fits             = 1'b1;
                end else if (b_space) begin
                    if (b == ptt_pkg::CH_NL) begin
                        n_line = sat_inc(r_line);
                    end
                end else if (b_digit) begin
                    n_run_kind  = RUN_CONST;
                    n_run_start = r_offset;
                    n_run_len   = OFFSET_BITS'(1);
                    n_acc       = acc_new;
                    n_fits      = fits_new;
                end else if (b_alpha) begin
                    n_run_kind  = RUN_VAR;
                    n_run_start = r_offset;
                    n_run_len   = OFFSET_BITS'(1);
                end else if (pk != ptt_pkg::KIND_EOF) begin
                    o_entry.has_own    = 1'b1;
                    o_entry.own.kind   = pk;
                    o_entry.own.length = 32'd1;
                end else begin
                    o_entry.has_own    = 1'b1;
                    o_entry.own.kind   = ptt_pkg::KIND_ERROR;
                    o_entry.own.length = 32'd1;
                    o_entry.own.bad    = b;
                    n_err              = 1'b1;
                end
                o_push = o_entry.has_run || o_entry.has_own;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_kind  <= RUN_NONE;
            r_run_start <= '0;
            r_run_len   <= '0;
            r_offset    <= '0;
            r_line      <= OFFSET_BITS'(1);
            r_acc       <= '0;
            r_fits      <= 1'b1;
            r_err       <= 1'b0;
        end else begin
            r_run_kind  <= n_run_kind;
            r_run_start <= n_run_start;
            r_run_len   <= n_run_len;
            r_offset    <= n_offset;
            r_line      <= n_line;
            r_acc       <= n_acc;
            r_fits      <= n_fits;
            r_err       <= n_err;
        end
    end

endmodule

// ===== rtl/core/ptt_queue.sv =====
// Small FIFO of token records between front and back.
module ptt_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ptt_pkg::t_entry i_wdata,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output ptt_pkg::t_entry o_rdata
);

    ptt_pkg::t_entry r_mem [ptt_pkg::QUEUE_DEPTH];

    logic [ptt_pkg::QUEUE_AW-1:0] r_wr, n_wr;
    logic [ptt_pkg::QUEUE_AW-1:0] r_rd, n_rd;
    logic [ptt_pkg::QUEUE_AW:0]   r_cnt, n_cnt;
    logic                         do_push;
    logic                         do_pop;

    assign o_full  = (r_cnt == (ptt_pkg::QUEUE_AW+1)'(ptt_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_rdata = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr  = do_push ? r_wr + 1'b1 : r_wr;
        n_rd  = do_pop ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== rtl/core/ptt_back.sv =====
// Back end: holds one record and emits its one or two tokens on the output channel.
module ptt_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  ptt_pkg::t_entry i_q_data,
    output logic            o_q_pop,
    ptt_out_if.source       o_out
);

    ptt_pkg::t_entry r_ent;
    logic            r_busy, n_busy;
    logic            r_run_done, n_run_done;
    logic            show_run;
    logic            last;
    logic            xfer;
    ptt_pkg::t_tok   tok;

    assign show_run = r_ent.has_run && !r_run_done;
    assign last     = !(show_run && r_ent.has_own);
    assign tok      = show_run ? r_ent.run : r_ent.own;
    assign xfer     = r_busy && o_out.ready;
    assign o_q_pop  = i_q_valid && (!r_busy || (xfer && last));

    assign o_out.valid        = r_busy;
    assign o_out.token_kind   = tok.kind;
    assign o_out.start_offset = tok.start;
    assign o_out.token_length = tok.length;
    assign o_out.line_number  = tok.line;
    assign o_out.const_value  = tok.value;
    assign o_out.const_fits   = tok.fits;
    assign o_out.bad_char     = tok.bad;
    assign o_out.last_of_run  = last;

    always_comb begin
        n_busy     = r_busy;
        n_run_done = r_run_done;
        if (o_q_pop) begin
            n_busy     = 1'b1;
            n_run_done = 1'b0;
        end else if (xfer) begin
            if (last) begin
                n_busy = 1'b0;
            end else begin
                n_run_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_ent <= i_q_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_run_done <= 1'b0;
        end else begin
            r_busy     <= n_busy;
            r_run_done <= n_run_done;
        end
    end

endmodule

// ===== rtl/core/proof_text_tokenizer.sv =====
// Top level: streaming tokenizer for proof text, one byte per transfer.
// Path: a token is written into the queue, then into the back end's holding register, then shown on the output.
// Throughput: one byte per cycle while the queue is not full; a byte that closes a run and gives its own
// token puts two tokens on the single output port, absorbed by a four-record queue.
// Reset: synchronous, active low; returns to the start of an empty text, line one.
module proof_text_tokenizer #(
    parameter int OFFSET_BITS = 32,
    parameter int VALUE_BITS  = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ptt_in_if.sink    i_in,
    ptt_out_if.source o_out
);

    logic            push;
    logic            q_full;
    logic            q_valid;
    logic            q_pop;
    ptt_pkg::t_entry wr_entry;
    ptt_pkg::t_entry rd_entry;

    ptt_front #(
        .OFFSET_BITS(OFFSET_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_q_full(q_full),
        .o_push  (push),
        .o_entry (wr_entry)
    );

    ptt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (wr_entry),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_rdata (rd_entry)
    );

    ptt_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(q_valid),
        .i_q_data (rd_entry),
        .o_q_pop  (q_pop),
        .o_out    (o_out)
    );

endmodule
